>>> rtl/core/fir_filter_49_tap_fixed_point_unit_defines.svh
// assertion macros used by the fir49 top-level rtl
`ifndef FIR_FILTER_49_TAP_FIXED_POINT_UNIT_DEFINES_SVH
`define FIR_FILTER_49_TAP_FIXED_POINT_UNIT_DEFINES_SVH

// concurrent check, switched off while reset is held
`define FIR49_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also holds during reset
`define FIR49_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/fir49_pkg.sv
`default_nettype none

package fir49_pkg;

    localparam int TAPS_DEF         = 49;
    localparam int SAMPLE_WIDTH_DEF = 10;
    localparam int SCALE_SHIFT_DEF  = 10;

    localparam int WEIGHT_WIDTH = 11;
    localparam int TABLE_LEN    = 49;
    localparam int TABLE_AW     = $clog2(TABLE_LEN);
    localparam int OUT_WIDTH    = 12;

    // low-pass taps scaled by 1024, truncated toward zero; symmetric about the center
    localparam logic signed [WEIGHT_WIDTH-1:0] TAP_WEIGHTS [TABLE_LEN] = '{
         11'sd4,    11'sd7,   -11'sd2,   -11'sd7,    11'sd3,
         11'sd0,   -11'sd9,    11'sd4,    11'sd4,   -11'sd13,
         11'sd3,    11'sd11,  -11'sd18,  -11'sd1,    11'sd22,
        -11'sd23,  -11'sd11,   11'sd40,  -11'sd26,  -11'sd34,
         11'sd77,  -11'sd29,  -11'sd123,  11'sd294,  11'sd652,
         11'sd294, -11'sd123, -11'sd29,   11'sd77,  -11'sd34,
        -11'sd26,   11'sd40,  -11'sd11,  -11'sd23,   11'sd22,
        -11'sd1,   -11'sd18,   11'sd11,   11'sd3,   -11'sd13,
         11'sd4,    11'sd4,   -11'sd9,    11'sd0,    11'sd3,
        -11'sd7,   -11'sd2,    11'sd7,    11'sd4
    };

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_FLUSH,
        S_DONE
    } t_state;

    // per-cycle commands from the sequencer to the datapath
    typedef struct packed {
        logic load;
        logic step;
        logic flush;
    } t_ctl;

    // taps past the end of the table weigh nothing
    function automatic logic signed [WEIGHT_WIDTH-1:0] tap_weight(input int idx);
        logic signed [WEIGHT_WIDTH-1:0] w;
        logic [31:0] uidx;
        uidx = 32'(idx);
        w = '0;
        if (idx >= 0 && idx < TABLE_LEN) begin
            w = TAP_WEIGHTS[uidx[TABLE_AW-1:0]];
        end
        return w;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/fir49_if.sv
`default_nettype none

interface fir49_in_if #(
    parameter int SAMPLE_WIDTH = fir49_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface fir49_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [fir49_pkg::OUT_WIDTH-1:0] filtered_out;

    modport source (output valid, output filtered_out, input ready);
    modport sink   (input valid, input filtered_out, output ready);
endinterface

`default_nettype wire

>>> rtl/core/fir49_line.sv
`default_nettype none

module fir49_line #(
    parameter int TAPS         = fir49_pkg::TAPS_DEF,
    parameter int SAMPLE_WIDTH = fir49_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire fir49_pkg::t_ctl           i_ctl,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic signed [SAMPLE_WIDTH-1:0] o_head
);

    // entry 0 is the newest sample; the ring turns once per tap
    logic signed [SAMPLE_WIDTH-1:0] r_line [TAPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < TAPS; j++) begin
                r_line[j] <= '0;
            end
        end else if (i_ctl.load) begin
            r_line[0] <= i_sample;
            for (int j = 1; j < TAPS; j++) begin
                r_line[j] <= r_line[j-1];
            end
        end else if (i_ctl.step) begin
            for (int j = 0; j < TAPS - 1; j++) begin
                r_line[j] <= r_line[j+1];
            end
            r_line[TAPS-1] <= r_line[0];
        end
    end

    assign o_head = r_line[0];

endmodule

`default_nettype wire

>>> rtl/core/fir49_mac.sv
`default_nettype none

module fir49_mac #(
    parameter int TAPS         = fir49_pkg::TAPS_DEF,
    parameter int SAMPLE_WIDTH = fir49_pkg::SAMPLE_WIDTH_DEF,
    parameter int SCALE_SHIFT  = fir49_pkg::SCALE_SHIFT_DEF
) (
    input  wire                                  i_clk,
    input  wire fir49_pkg::t_ctl                 i_ctl,
    input  wire logic signed [SAMPLE_WIDTH-1:0]  i_head,
    input  wire logic [$clog2(TAPS)-1:0]         i_tap,
    output logic signed [fir49_pkg::OUT_WIDTH-1:0] o_result
);

    localparam int WW     = fir49_pkg::WEIGHT_WIDTH;
    localparam int PROD_W = SAMPLE_WIDTH + WW;
    localparam int ACC_W  = PROD_W + $clog2(TAPS);
    localparam int OW     = fir49_pkg::OUT_WIDTH;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (OW - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] BIAS   = ACC_W'((2 ** SCALE_SHIFT) - 1);

    logic signed [WW-1:0]     weight;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  biased;
    logic signed [ACC_W-1:0]  quot;

    assign weight   = fir49_pkg::tap_weight(int'(i_tap));
    assign prod_ext = ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_prod <= '0;
            r_acc  <= '0;
        end else if (i_ctl.step) begin
            r_prod <= i_head * weight;
            r_acc  <= r_acc + prod_ext;
        end else if (i_ctl.flush) begin
            r_acc  <= r_acc + prod_ext;
        end
    end

    // divide toward zero: negative sums get the bias before the arithmetic shift
    always_comb begin
        biased = r_acc + (r_acc[ACC_W-1] ? BIAS : '0);
        quot   = biased >>> SCALE_SHIFT;
        if (quot > SAT_HI) begin
            o_result = SAT_HI[OW-1:0];
        end else if (quot < SAT_LO) begin
            o_result = SAT_LO[OW-1:0];
        end else begin
            o_result = quot[OW-1:0];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/fir_filter_49_tap_fixed_point_unit.sv
// 49-tap direct-form fir low-pass filter for signed accelerometer samples. each
// accepted input word yields exactly one output word: the sum of the newest
// sample and the previous TAPS-1 samples times a fixed table of weights scaled
// by 2^SCALE_SHIFT, divided by 2^SCALE_SHIFT with truncation toward zero and
// saturated to signed 12 bits. samples flow word-serially: the delay line is a
// ring of registers that turns one tap per clock past a single narrow multiplier,
// so each word is done with before the next word can be taken: the multiply-
// accumulate takes one tap per clock, the flush state drains the product
// register, the done state loads the rounded and saturated sum into the output
// register and the unit goes back to idle to take the next word.
// the round and saturate step waits for as long as the output register still
// holds a word that has not been taken. the input is taken only while the unit
// is idle; a finished word waits in the output register, so the next sample can
// be accepted before the previous result is taken. the delay line clears to zero
// on reset, with no clearing pass.
`default_nettype none

`include "fir_filter_49_tap_fixed_point_unit_defines.svh"

module fir_filter_49_tap_fixed_point_unit #(
    parameter int TAPS         = fir49_pkg::TAPS_DEF,
    parameter int SAMPLE_WIDTH = fir49_pkg::SAMPLE_WIDTH_DEF,
    parameter int SCALE_SHIFT  = fir49_pkg::SCALE_SHIFT_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    fir49_in_if.sink     i_sample,
    fir49_out_if.source  o_result
);

    localparam int TW = $clog2(TAPS);
    localparam int OW = fir49_pkg::OUT_WIDTH;
    localparam logic [TW-1:0] LAST_TAP = TW'(TAPS - 1);

    fir49_pkg::t_state r_state, n_state;
    logic [TW-1:0]     r_tap, n_tap;
    fir49_pkg::t_ctl   ctl;

    logic signed [SAMPLE_WIDTH-1:0] head;
    logic signed [OW-1:0]           result;
    logic signed [OW-1:0]           r_out;
    logic                           r_out_vld, n_out_vld;

    logic in_acc;     // input word taken this cycle
    logic out_free;   // output register empty or draining this cycle
    logic load_out;   // finished word moves into the output register

    assign in_acc   = i_sample.valid && i_sample.ready;
    assign out_free = !r_out_vld || o_result.ready;

    // sequencer: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fir49_pkg::S_IDLE: begin
                if (in_acc) n_state = fir49_pkg::S_MAC;
            end
            fir49_pkg::S_MAC: begin
                if (r_tap == LAST_TAP) n_state = fir49_pkg::S_FLUSH;
            end
            fir49_pkg::S_FLUSH: begin
                n_state = fir49_pkg::S_DONE;
            end
            fir49_pkg::S_DONE: begin
                if (out_free) n_state = fir49_pkg::S_IDLE;
            end
            default: begin
                n_state = fir49_pkg::S_IDLE;
            end
        endcase
    end

    // sequencer: outputs
    always_comb begin
        ctl.load  = in_acc;
        ctl.step  = (r_state == fir49_pkg::S_MAC);
        ctl.flush = (r_state == fir49_pkg::S_FLUSH);
        load_out  = (r_state == fir49_pkg::S_DONE) && out_free;

        // tap counter follows the ring position
        n_tap = r_tap;
        if (ctl.load) begin
            n_tap = '0;
        end else if (ctl.step) begin
            n_tap = (r_tap == LAST_TAP) ? '0 : r_tap + TW'(1);
        end

        n_out_vld = r_out_vld;
        if (load_out) begin
            n_out_vld = 1'b1;
        end else if (o_result.ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fir49_pkg::S_IDLE;
            r_tap     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_tap     <= n_tap;
            r_out_vld <= n_out_vld;
        end
    end

    // output word register, payload only
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= result;
        end
    end

    fir49_line #(
        .TAPS         (TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_line (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_sample (i_sample.sample_in),
        .o_head   (head)
    );

    fir49_mac #(
        .TAPS         (TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .SCALE_SHIFT  (SCALE_SHIFT)
    ) u_mac (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_head   (head),
        .i_tap    (r_tap),
        .o_result (result)
    );

    assign i_sample.ready        = (r_state == fir49_pkg::S_IDLE);
    assign o_result.valid        = r_out_vld;
    assign o_result.filtered_out = r_out;

    // an accepted word starts the multiply-accumulate at the first tap
    `FIR49_ASSERT_RST(a_accept_starts, i_clk, i_rst_n,
        in_acc |=> (r_state == fir49_pkg::S_MAC && r_tap == '0),
        "accepted word did not start at tap zero")

    // the last tap always hands over to the drain cycle
    `FIR49_ASSERT_RST(a_last_tap_flush, i_clk, i_rst_n,
        (r_state == fir49_pkg::S_MAC && r_tap == LAST_TAP) |=> r_state == fir49_pkg::S_FLUSH,
        "last tap did not lead to flush")

    // a new output word only appears out of the done state
    `FIR49_ASSERT_RST(a_out_from_done, i_clk, i_rst_n,
        $rose(o_result.valid) |-> $past(r_state) == fir49_pkg::S_DONE,
        "output word appeared outside done")

    // once reset has been sampled low, no word is shown and the sequencer is idle
    `FIR49_ASSERT_ALWAYS(a_reset_quiet, i_clk,
        !i_rst_n |=> (!o_result.valid && r_state == fir49_pkg::S_IDLE),
        "state not cleared by reset")

endmodule

`default_nettype wire
